@@ design/phcl_pkg.sv @@
// Shared types, constants and helpers of the per-host connection limiter.
package phcl_pkg;

  // Host table depth; a power of two, so the slot index is a plain truncation.
  localparam int HOST_SLOTS = 256;
  localparam int SLOT_W     = $clog2(HOST_SLOTS);

  localparam logic [9:0] COUNT_MAX = 10'd1023;
  localparam logic [7:0] KILLS_MAX = 8'd255;

  // Action codes
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_WARN   = 3'd1;
  localparam logic [2:0] ACT_KILL   = 3'd2;
  localparam logic [2:0] ACT_BAN    = 3'd3;
  localparam logic [2:0] ACT_EXEMPT = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_DEFAULT_ALLOWED = 3'd0;
  localparam logic [2:0] REG_DEFAULT_WARN    = 3'd1;
  localparam logic [2:0] REG_BAN_ENABLED     = 3'd2;
  localparam logic [2:0] REG_GRACE_ALLOWANCE = 3'd3;
  localparam logic [2:0] REG_INCREASE_MODE   = 3'd4;
  localparam logic [2:0] REG_GRACE_WINDOW    = 3'd5;

  // One row of the host table
  typedef struct packed {
    logic [9:0]  count;
    logic [9:0]  logged;
    logic [31:0] first_kill;
    logic [7:0]  grace_kills;
  } row_t;

  // Fields of one event, without the slot
  typedef struct packed {
    logic        is_disc;
    logic        logged_in;
    logic        ex_hit;
    logic [7:0]  ex_allowed;
    logic [7:0]  ex_warn;
    logic        ban_exempt;
    logic        ban_sent;
    logic [31:0] now;
  } evt_t;

  // Configuration registers
  typedef struct packed {
    logic [7:0]  def_allowed;
    logic [7:0]  def_warn;
    logic        ban_enabled;
    logic [7:0]  grace_allowance;
    logic        increase_mode;
    logic [15:0] grace_window;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [2:0] action;
    logic [9:0] clone;
    logic [8:0] limit;
    logic [7:0] grace_left;
  } res_t;

  // Map the host field onto a table row
  function automatic logic [SLOT_W-1:0] slot_of(logic [7:0] host);
    logic [16:0] ext;
    ext = 17'(host);
    return ext[SLOT_W-1:0];
  endfunction

  // Raise a nonzero limit by the logged-in count, capped at twice the base
  function automatic logic [8:0] raise_limit(logic [7:0] base, logic [9:0] logged);
    logic [10:0] sum;
    logic [8:0]  dbl;
    sum = 11'(base) + 11'(logged);
    dbl = {base, 1'b0};
    if (base == 8'd0) return 9'd0;
    if (sum > 11'(dbl)) return dbl;
    return sum[8:0];
  endfunction

endpackage

@@ design/per_host_connection_limiter.sv @@
// Top level of the per-host connection limiter: host table, control and ports.
//
// Usage: each transfer on the in_ channel is one connect or disconnect event
// for one host row (in_tuser: 0 connect, 1 disconnect). For every event the
// out_ channel delivers exactly one result: the action, the row's connection
// count after the event, the allowed limit in force and the grace kills left.
// The host table sits in one synchronous memory; an event reads its row
// into the read register on the transfer, and once the output register is
// free the row is written back and the result loaded into the output
// register; no new event is taken before that. Since the row is written
// back before the next event can read, no forwarding is needed.
// When out_tready is low the result waits in the output register; one more
// event is accepted and read meanwhile, and then it waits for the register
// to drain. Reset (rst_n low, synchronous) restores the default registers
// and marks every host row as empty through per-row valid bits, so the block is
// ready in the first cycle after reset. Configuration writes on the cfg_ port
// take effect at once; make them only while idle, the block does not enforce it.
module per_host_connection_limiter (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  // Event input
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] host_slot, [8] user_logged_in, [9] exempt_hit, [17:10] exempt_allowed,
  // [25:18] exempt_warn, [26] ban_exempt_user, [27] ban_already_sent,
  // [59:28] now_seconds, [63:60] zero
  input  logic [63:0] in_tdata,
  // [0] req_type
  input  logic        in_tuser,
  // Result output
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] action, [12:3] clone_count, [21:13] limit_in_force, [29:22] grace_left,
  // [31:30] zero
  output logic [31:0] out_tdata
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  logic                            state_r, state_nxt;
  phcl_pkg::cfg_t                  cfg_r;
  phcl_pkg::evt_t                  evt_r;
  logic [phcl_pkg::SLOT_W-1:0]     slot_r;
  logic [phcl_pkg::HOST_SLOTS-1:0] row_valid_r;
  logic                            rd_valid_r;
  phcl_pkg::row_t                  rd_data_r;
  phcl_pkg::row_t                  row_cur;
  phcl_pkg::row_t                  row_new;
  phcl_pkg::res_t                  res;
  phcl_pkg::res_t                  out_res_r;
  logic                            out_valid_r, out_valid_nxt;
  logic                            in_xfer;
  logic                            advance;
  logic [phcl_pkg::SLOT_W-1:0]     in_slot;

  phcl_pkg::row_t mem [phcl_pkg::HOST_SLOTS];

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign in_slot   = phcl_pkg::slot_of(in_tdata[7:0]);
  assign advance   = (state_r == ST_CALC) && (!out_valid_r || out_tready);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.def_allowed     <= 8'd5;
      cfg_r.def_warn        <= 8'd4;
      cfg_r.ban_enabled     <= 1'b0;
      cfg_r.grace_allowance <= 8'd0;
      cfg_r.increase_mode   <= 1'b0;
      cfg_r.grace_window    <= 16'd180;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        phcl_pkg::REG_DEFAULT_ALLOWED: cfg_r.def_allowed     <= cfg_wdata[7:0];
        phcl_pkg::REG_DEFAULT_WARN:    cfg_r.def_warn        <= cfg_wdata[7:0];
        phcl_pkg::REG_BAN_ENABLED:     cfg_r.ban_enabled     <= cfg_wdata[0];
        phcl_pkg::REG_GRACE_ALLOWANCE: cfg_r.grace_allowance <= cfg_wdata[7:0];
        phcl_pkg::REG_INCREASE_MODE:   cfg_r.increase_mode   <= cfg_wdata[0];
        phcl_pkg::REG_GRACE_WINDOW:    cfg_r.grace_window    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Host table: read on transfer, write back when the result is loaded
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_data_r <= mem[in_slot];
    end
    if (advance) begin
      mem[slot_r] <= row_new;
    end
  end

  // Row valid bits: an invalid row reads as all zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_valid_r  <= 1'b0;
    end else begin
      if (in_xfer) begin
        rd_valid_r <= row_valid_r[in_slot];
      end
      if (advance) begin
        row_valid_r[slot_r] <= 1'b1;
      end
    end
  end

  // Capture the event fields
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      slot_r           <= in_slot;
      evt_r.is_disc    <= in_tuser;
      evt_r.logged_in  <= in_tdata[8];
      evt_r.ex_hit     <= in_tdata[9];
      evt_r.ex_allowed <= in_tdata[17:10];
      evt_r.ex_warn    <= in_tdata[25:18];
      evt_r.ban_exempt <= in_tdata[26];
      evt_r.ban_sent   <= in_tdata[27];
      evt_r.now        <= in_tdata[59:28];
    end
  end

  assign row_cur = rd_valid_r ? rd_data_r : '0;

  phcl_eval u_eval (
    .row_in  (row_cur),
    .evt     (evt_r),
    .cfg     (cfg_r),
    .row_out (row_new),
    .res     (res)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_CALC;
      ST_CALC: if (advance) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register: load on advance, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (advance) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.grace_left, out_res_r.limit,
                       out_res_r.clone, out_res_r.action};

endmodule

@@ design/phcl_eval.sv @@
// Row update and action decision for one event.
module phcl_eval (
  input  phcl_pkg::row_t row_in,
  input  phcl_pkg::evt_t evt,
  input  phcl_pkg::cfg_t cfg,
  output phcl_pkg::row_t row_out,
  output phcl_pkg::res_t res
);

  logic [9:0]  conn_cnt;
  logic [9:0]  conn_lg;
  logic [7:0]  base_allowed;
  logic [7:0]  base_warn;
  logic [8:0]  allowed;
  logic [8:0]  warn;
  logic        expired;
  logic        over;
  logic        warn_hit;
  logic        kill_ok;
  logic [9:0]  disc_cnt;
  logic [2:0]  action;

  // Saturating counts after a connect
  assign conn_cnt = (row_in.count < phcl_pkg::COUNT_MAX) ? row_in.count + 10'd1 : row_in.count;
  assign conn_lg  = (evt.logged_in && row_in.logged < phcl_pkg::COUNT_MAX)
                    ? row_in.logged + 10'd1 : row_in.logged;

  // Pick the limits and raise them in increase mode
  assign base_allowed = evt.ex_hit ? evt.ex_allowed : cfg.def_allowed;
  assign base_warn    = evt.ex_hit ? evt.ex_warn    : cfg.def_warn;
  assign allowed = cfg.increase_mode ? phcl_pkg::raise_limit(base_allowed, conn_lg)
                                     : 9'(base_allowed);
  assign warn    = cfg.increase_mode ? phcl_pkg::raise_limit(base_warn, conn_lg)
                                     : 9'(base_warn);

  // Grace window check without wrap
  assign expired = (33'(row_in.first_kill) + 33'(cfg.grace_window)) < 33'(evt.now);

  assign over     = (allowed != 9'd0) && (conn_cnt > {1'b0, allowed});
  assign warn_hit = (warn != 9'd0) && (conn_cnt >= {1'b0, warn});
  assign kill_ok  = !cfg.ban_enabled || (row_in.grace_kills < cfg.grace_allowance) ||
                    ((cfg.grace_allowance != 8'd0) && expired);
  assign disc_cnt = row_in.count - 10'd1;

  always_comb begin
    row_out = row_in;
    action  = phcl_pkg::ACT_NONE;
    if (evt.is_disc) begin
      // Disconnect: drop the counts, clear an emptied row
      if (row_in.count != 10'd0) begin
        row_out.count = disc_cnt;
        if (evt.logged_in && row_in.logged != 10'd0) begin
          row_out.logged = row_in.logged - 10'd1;
        end
        if (disc_cnt == 10'd0) begin
          row_out = '0;
        end
      end
    end else begin
      // Connect: count, then decide
      row_out.count  = conn_cnt;
      row_out.logged = conn_lg;
      if (over) begin
        if (evt.ban_exempt) begin
          action = phcl_pkg::ACT_EXEMPT;
        end else if (kill_ok) begin
          if (expired) begin
            row_out.first_kill  = evt.now;
            row_out.grace_kills = 8'd1;
          end else if (row_in.grace_kills < phcl_pkg::KILLS_MAX) begin
            row_out.grace_kills = row_in.grace_kills + 8'd1;
          end
          action = phcl_pkg::ACT_KILL;
        end else begin
          action = evt.ban_sent ? phcl_pkg::ACT_NONE : phcl_pkg::ACT_BAN;
        end
      end else if (warn_hit) begin
        action = phcl_pkg::ACT_WARN;
      end
    end
  end

  // Result fields
  always_comb begin
    res.action     = action;
    res.clone      = row_out.count;
    res.limit      = evt.is_disc ? 9'd0 : allowed;
    res.grace_left = (cfg.grace_allowance > row_out.grace_kills)
                     ? cfg.grace_allowance - row_out.grace_kills : 8'd0;
  end

endmodule

@@ design/phcl_checker.sv @@
// Port-level assertions for the per-host connection limiter and their bind.
module phcl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // After an accepted event in_tready is low, so events are never taken back to back
  a_in_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("event accepted in consecutive cycles");

  // No result is shown right after reset, since the output valid is reset low
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  // Kill, ban and exempt only occur above a nonzero limit
  a_over_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == phcl_pkg::ACT_KILL ||
                   out_tdata[2:0] == phcl_pkg::ACT_BAN ||
                   out_tdata[2:0] == phcl_pkg::ACT_EXEMPT)
    |-> (out_tdata[21:13] != 9'd0) && (out_tdata[12:3] > {1'b0, out_tdata[21:13]}))
    else $error("over-limit action without exceeding the limit");

  // Action codes stay within the defined set
  a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= phcl_pkg::ACT_EXEMPT)
    else $error("undefined action code");

endmodule

bind per_host_connection_limiter phcl_checker u_phcl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ dv/per_host_connection_limiter_check.sv @@
// Checker of the per-host connection limiter: watches both channels, predicts and compares.
module per_host_connection_limiter_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the registers
  logic [7:0]  lim_allowed;
  logic [7:0]  lim_warn;
  logic        ban_on;
  logic [7:0]  grace_allow;
  logic        boost_on;
  logic [15:0] window_len;

  // Shadow copy of the host table
  logic [9:0]  conn_tbl      [phcl_pkg::HOST_SLOTS];
  logic [9:0]  login_tbl     [phcl_pkg::HOST_SLOTS];
  logic [31:0] kill_time_tbl [phcl_pkg::HOST_SLOTS];
  logic [7:0]  kill_tbl      [phcl_pkg::HOST_SLOTS];

  // Verdicts owed by the block, oldest first
  phcl_pkg::res_t verdict_q[$];
  phcl_pkg::res_t want;
  phcl_pkg::res_t got;

  initial fail_count = 0;
  initial pending = 0;

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    $display("mismatch: %s expected %0d got %0d", what, exp_v, got_v);
    fail_count++;
  endtask

  // Raise a nonzero limit by the logged-in count, never past double
  function automatic logic [8:0] boosted(input logic [7:0] base, input logic [9:0] logged);
    int sum;
    if (base == 8'd0) return 9'd0;
    sum = int'(base) + int'(logged);
    if (sum > 2 * int'(base)) sum = 2 * int'(base);
    return 9'(sum);
  endfunction

  // Apply one event to the shadow table and return the verdict it earns
  function automatic phcl_pkg::res_t judge_event(input logic [63:0] data, input logic disc);
    phcl_pkg::res_t r;
    int unsigned    row;
    logic           logged;
    logic           ex_hit;
    logic [7:0]     ex_al;
    logic [7:0]     ex_wn;
    logic           ban_ex;
    logic           ban_snt;
    logic [31:0]    stamp;
    logic [8:0]     allow9;
    logic [8:0]     warn9;
    logic [9:0]     cnt;
    logic           expired;
    row     = int'(data[7:0]) % phcl_pkg::HOST_SLOTS;
    logged  = data[8];
    ex_hit  = data[9];
    ex_al   = data[17:10];
    ex_wn   = data[25:18];
    ban_ex  = data[26];
    ban_snt = data[27];
    stamp   = data[59:28];
    r        = '0;
    r.action = phcl_pkg::ACT_NONE;
    if (disc) begin
      // Drop one connection; an emptied row forgets everything
      if (conn_tbl[row] != 10'd0) begin
        conn_tbl[row] = conn_tbl[row] - 10'd1;
        if (logged && login_tbl[row] != 10'd0) login_tbl[row] = login_tbl[row] - 10'd1;
        if (conn_tbl[row] == 10'd0) begin
          login_tbl[row]     = '0;
          kill_time_tbl[row] = '0;
          kill_tbl[row]      = '0;
        end
      end
    end else begin
      // Count the connection, saturating
      if (conn_tbl[row] < phcl_pkg::COUNT_MAX) conn_tbl[row] = conn_tbl[row] + 10'd1;
      if (logged && login_tbl[row] < phcl_pkg::COUNT_MAX) begin
        login_tbl[row] = login_tbl[row] + 10'd1;
      end
      cnt    = conn_tbl[row];
      allow9 = {1'b0, ex_hit ? ex_al : lim_allowed};
      warn9  = {1'b0, ex_hit ? ex_wn : lim_warn};
      if (boost_on) begin
        allow9 = boosted(allow9[7:0], login_tbl[row]);
        warn9  = boosted(warn9[7:0], login_tbl[row]);
      end
      r.limit = allow9;
      if (allow9 != 9'd0 && cnt > {1'b0, allow9}) begin
        expired = (33'(kill_time_tbl[row]) + 33'(window_len)) < 33'(stamp);
        if (ban_ex) begin
          r.action = phcl_pkg::ACT_EXEMPT;
        end else if (!ban_on || kill_tbl[row] < grace_allow ||
                     (grace_allow != 8'd0 && expired)) begin
          // Kill, restarting the grace window once it has run out
          if (expired) begin
            kill_time_tbl[row] = stamp;
            kill_tbl[row]      = 8'd1;
          end else if (kill_tbl[row] < phcl_pkg::KILLS_MAX) begin
            kill_tbl[row] = kill_tbl[row] + 8'd1;
          end
          r.action = phcl_pkg::ACT_KILL;
        end else begin
          r.action = ban_snt ? phcl_pkg::ACT_NONE : phcl_pkg::ACT_BAN;
        end
      end else if (warn9 != 9'd0 && {1'b0, cnt} >= {1'b0, warn9}) begin
        r.action = phcl_pkg::ACT_WARN;
      end
    end
    r.clone      = conn_tbl[row];
    r.grace_left = (grace_allow > kill_tbl[row]) ? grace_allow - kill_tbl[row] : 8'd0;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      lim_allowed = 8'd5;
      lim_warn    = 8'd4;
      ban_on      = 1'b0;
      grace_allow = 8'd0;
      boost_on    = 1'b0;
      window_len  = 16'd180;
      for (int i = 0; i < phcl_pkg::HOST_SLOTS; i++) begin
        conn_tbl[i]      = '0;
        login_tbl[i]     = '0;
        kill_time_tbl[i] = '0;
        kill_tbl[i]      = '0;
      end
      verdict_q.delete();
    end else begin
      // Compare an output transfer with the oldest verdict
      if (out_tvalid && out_tready) begin
        got.action     = out_tdata[2:0];
        got.clone      = out_tdata[12:3];
        got.limit      = out_tdata[21:13];
        got.grace_left = out_tdata[29:22];
        if (verdict_q.size() == 0) begin
          report_mismatch("result with nothing outstanding, data", 0, out_tdata);
        end else begin
          want = verdict_q.pop_front();
          if (got.action != want.action)
            report_mismatch("action", want.action, got.action);
          if (got.clone != want.clone)
            report_mismatch("clone_count", want.clone, got.clone);
          if (got.limit != want.limit)
            report_mismatch("limit_in_force", want.limit, got.limit);
          if (got.grace_left != want.grace_left)
            report_mismatch("grace_left", want.grace_left, got.grace_left);
        end
      end
      // Track register writes
      if (cfg_we) begin
        case (cfg_addr)
          phcl_pkg::REG_DEFAULT_ALLOWED: lim_allowed = cfg_wdata[7:0];
          phcl_pkg::REG_DEFAULT_WARN:    lim_warn    = cfg_wdata[7:0];
          phcl_pkg::REG_BAN_ENABLED:     ban_on      = cfg_wdata[0];
          phcl_pkg::REG_GRACE_ALLOWANCE: grace_allow = cfg_wdata[7:0];
          phcl_pkg::REG_INCREASE_MODE:   boost_on    = cfg_wdata[0];
          phcl_pkg::REG_GRACE_WINDOW:    window_len  = cfg_wdata;
          default: ;
        endcase
      end
      // Predict each input transfer
      if (in_tvalid && in_tready) verdict_q.push_back(judge_event(in_tdata, in_tuser));
    end
    pending = verdict_q.size();
  end

endmodule

@@ dv/per_host_connection_limiter_test.sv @@
// Testbench top of the per-host connection limiter: clock, reset, stimulus and verdict.
module per_host_connection_limiter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT   = 2000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 37;
  localparam int FLOOD_ITEMS   = 1030;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  // [7:0] host_slot, [8] user_logged_in, [9] exempt_hit, [17:10] exempt_allowed,
  // [25:18] exempt_warn, [26] ban_exempt_user, [27] ban_already_sent,
  // [59:28] now_seconds, [63:60] zero
  logic [63:0] in_tdata;
  // [0] req_type
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  // [2:0] action, [12:3] clone_count, [21:13] limit_in_force, [29:22] grace_left
  logic [31:0] out_tdata;

  int          fail_count;
  int          pending;
  logic        no_idle = 1'b0;
  logic [31:0] wall_clock;
  logic [7:0]  host_pool [6];

  per_host_connection_limiter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  per_host_connection_limiter_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offer one event after a random gap and hold it until the transfer
  task automatic send_event(input logic disc, input logic [7:0] host, input logic logged,
                            input logic ex_hit, input logic [7:0] ex_al,
                            input logic [7:0] ex_wn, input logic ban_ex,
                            input logic ban_snt, input logic [31:0] stamp);
    int gap;
    gap = no_idle ? 0 : int'($urandom_range(0, 6));
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  = disc;
    in_tdata  = {4'd0, stamp, ban_snt, ban_ex, ex_wn, ex_al, ex_hit, logged, host};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Drain all outstanding results, then let the pipeline empty
  task automatic settle_block();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
  endtask

  // Write every register while the block is idle
  task automatic set_config(input logic [7:0] al, input logic [7:0] wn, input logic ban,
                            input logic [7:0] grace, input logic inc,
                            input logic [15:0] win);
    settle_block();
    put_reg(phcl_pkg::REG_DEFAULT_ALLOWED, {8'd0, al});
    put_reg(phcl_pkg::REG_DEFAULT_WARN, {8'd0, wn});
    put_reg(phcl_pkg::REG_BAN_ENABLED, {15'd0, ban});
    put_reg(phcl_pkg::REG_GRACE_ALLOWANCE, {8'd0, grace});
    put_reg(phcl_pkg::REG_INCREASE_MODE, {15'd0, inc});
    put_reg(phcl_pkg::REG_GRACE_WINDOW, win);
    cfg_we = 1'b0;
  endtask

  // Mostly connect/disconnect traffic on a few hosts, with some raw noise
  task automatic random_event(input int drop_pct);
    logic [7:0] al;
    logic [7:0] wn;
    if ($urandom_range(0, 99) < 8) begin
      send_event(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
    end else begin
      al = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 8));
      wn = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 8));
      // Advance the clock slowly, with the odd long jump past the window
      if ($urandom_range(0, 9) == 0) wall_clock = wall_clock + $urandom_range(0, 400);
      else wall_clock = wall_clock + $urandom_range(0, 3);
      send_event($urandom_range(0, 99) < drop_pct, host_pool[$urandom_range(0, 5)],
                 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0, al, wn,
                 $urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)), wall_clock);
    end
  endtask

  // Receiver: stall a random number of cycles before each result
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : int'($urandom_range(0, 6));
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("per_host_connection_limiter test failed");
    $finish;
  end

  initial begin
    logic [7:0]  p_al;
    logic [7:0]  p_wn;
    logic        p_ban;
    logic [7:0]  p_grace;
    logic        p_inc;
    logic [15:0] p_win;
    int          drop_pct;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    wall_clock = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset settings, empty row, warn then kill, exempt, limit extremes
    send_event(1'b1, 8'd0, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0, 32'd0);
    for (int i = 0; i < 5; i++) begin
      send_event(1'b0, 8'd0, i[0], 1'b0, 8'd0, 8'd0, 1'b0, 1'b0, 32'd10);
    end
    send_event(1'b0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0, 32'd10);
    send_event(1'b0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 32'd10);
    send_event(1'b1, 8'd0, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0, 32'd10);
    send_event(1'b0, 8'd255, 1'b1, 1'b1, 8'hFF, 8'hFF, 1'b0, 1'b1, 32'hFFFF_FFFF);
    send_event(1'b0, 8'd255, 1'b0, 1'b1, 8'd0, 8'd1, 1'b0, 1'b0, 32'd0);

    // Directed: bans after the grace kill, expired window, ban already issued
    set_config(8'd1, 8'd0, 1'b1, 8'd1, 1'b0, 16'd0);
    send_event(1'b0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0, 32'd11);
    send_event(1'b0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0, 32'd11);
    send_event(1'b0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b1, 32'd11);
    send_event(1'b0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0, 32'd12);

    // Directed: increase mode, then empty the row again
    set_config(8'd2, 8'd2, 1'b0, 8'd3, 1'b1, 16'd180);
    for (int i = 0; i < 3; i++) begin
      send_event(1'b0, 8'd9, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0, 32'd20);
    end
    send_event(1'b0, 8'd9, 1'b1, 1'b1, 8'hFF, 8'hFF, 1'b0, 1'b0, 32'd20);
    for (int i = 0; i < 4; i++) begin
      send_event(1'b1, 8'd9, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0, 32'd21);
    end
    send_event(1'b1, 8'd9, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0, 32'd21);

    // Flood one host so the counts and the grace kills saturate
    set_config(8'd3, 8'd2, 1'b0, 8'd5, 1'b1, 16'hFFFF);
    for (int i = 0; i < FLOOD_ITEMS; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_event(1'b0, 8'd200, $urandom_range(0, 19) != 0, $urandom_range(0, 3) == 0,
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 $urandom_range(0, 15) == 0, 1'($urandom_range(0, 1)), 32'd1000);
    end

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin p_al = 8'd5;   p_wn = 8'd4;   p_ban = 1'b0; p_grace = 8'd0;
                 p_inc = 1'b0;  p_win = 16'd180; end
        1: begin p_al = 8'd0;   p_wn = 8'd255; p_ban = 1'b1; p_grace = 8'd255;
                 p_inc = 1'b1;  p_win = 16'hFFFF; end
        2: begin p_al = 8'd255; p_wn = 8'd0;   p_ban = 1'b1; p_grace = 8'd0;
                 p_inc = 1'b0;  p_win = 16'd0; end
        3: begin p_al = 8'd3;   p_wn = 8'd2;   p_ban = 1'b1; p_grace = 8'd2;
                 p_inc = 1'b0;  p_win = 16'd20; end
        4: begin p_al = 8'd2;   p_wn = 8'd1;   p_ban = 1'b1; p_grace = 8'd1;
                 p_inc = 1'b1;  p_win = 16'd5; end
        5: begin p_al = 8'd1;   p_wn = 8'd0;   p_ban = 1'b0; p_grace = 8'd3;
                 p_inc = 1'b1;  p_win = 16'd100; end
        default: begin
          p_al    = 8'($urandom_range(0, 8));
          p_wn    = 8'($urandom_range(0, 8));
          p_ban   = 1'($urandom_range(0, 1));
          p_grace = 8'($urandom_range(0, 4));
          p_inc   = 1'($urandom_range(0, 1));
          p_win   = 16'($urandom_range(0, 300));
        end
      endcase
      no_idle = 1'b0;
      set_config(p_al, p_wn, p_ban, p_grace, p_inc, p_win);
      // Pick the hosts of this phase, the end rows among them
      host_pool[0] = 8'd0;
      host_pool[1] = 8'd255;
      for (int h = 2; h < 6; h++) host_pool[h] = 8'($urandom_range(0, 255));
      // One phase starts just short of the clock wrapping around
      wall_clock = (p == 5) ? 32'hFFFF_FF00 : 32'($urandom_range(0, 5000));
      drop_pct   = int'($urandom_range(35, 60));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        random_event(drop_pct);
      end
    end

    // Wait for the last results, then give the verdict
    settle_block();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("per_host_connection_limiter test passed");
    end else begin
      $display("per_host_connection_limiter test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/phcl_pkg.sv
design/phcl_eval.sv
design/per_host_connection_limiter.sv
design/phcl_checker.sv
dv/per_host_connection_limiter_check.sv
dv/per_host_connection_limiter_test.sv
